// File: rtl/lpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared widths, register indexes and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int VAL_W   = 48;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 16;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 2;
  localparam int KCNT_W  = 7;
  // Dividend width of the shared divider: covers the scaled position and
  // the magnitude of the recurrence difference.
  localparam int DIV_W   = 55;
  localparam int DCNT_W  = 6;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAX_POSITION = 2'd0,
    CFG_NUM_TERMS    = 2'd1
  } cfg_idx_t;

  localparam logic signed [63:0] SAT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] SAT_MIN = -64'sd140737488355328;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[VAL_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/lpe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_in_if
// Position channel: valid/ready handshake carrying one sequence position.
// ----------------------------------------------------------------------------
interface lpe_in_if import lpe_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

// File: rtl/lpe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_out_if
// Term channel: valid/ready handshake carrying one polynomial value.
// ----------------------------------------------------------------------------
interface lpe_out_if import lpe_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        term_index;
  logic signed [VAL_W-1:0] term_value;
  logic                    last_term;

  modport source (output valid, output term_index, output term_value,
                  output last_term, input ready);
  modport sink   (input valid, input term_index, input term_value,
                  input last_term, output ready);
endinterface

// File: rtl/laguerre_polynomial_embedding_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laguerre_polynomial_embedding_unit
// Maps a position onto [-1,1] and emits the Laguerre values L_0..L_{K-1}.
//
//   channel   dir  handshake       payload
//   in_if     in   valid/ready     position
//   out_if    out  valid/ready     term_index, term_value, last_term
//   cfg_*     in   cfg_we          cfg_index, cfg_data
//
// L_0 is shown once the normalising division is through. L_1 follows in the
// cycle after L_0 is taken. Every later term passes through the shared
// one-bit-a-cycle divider for the divide by n+1, four partial products of the
// 24x24 multiplier and the sequencing states COEF, SAT, SUB and DFIN.
// Output stalls hold the sequencer in place.
// Reset is synchronous and active low; no item is accepted until a run ends.
// ----------------------------------------------------------------------------
module laguerre_polynomial_embedding_unit import lpe_pkg::*; #(
  parameter int MAX_TERMS = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  lpe_in_if.sink            in_if,
  lpe_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int XW = FRAC_BITS + 18;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_DFIN = 8'b0000_0100,
    S_OUT  = 8'b0000_1000,
    S_COEF = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_SUB  = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         maxpos_r, maxpos_nxt;
  logic [KCNT_W-1:0]        nterms_r, nterms_nxt;
  logic [KCNT_W-1:0]        k_r, k_nxt;
  logic signed [XW-1:0]     x_r, x_nxt;
  logic signed [VAL_W-1:0]  prev_r, prev_nxt;
  logic signed [VAL_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]         term_r, term_nxt;
  logic                     last_r, last_nxt;
  logic                     oval_r, oval_nxt;
  logic                     forx_r, forx_nxt;
  logic [DIV_W-1:0]         quo_r, quo_nxt;
  logic [CFG_W-1:0]         rem_r, rem_nxt;
  logic [CFG_W-1:0]         den_r, den_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic [VAL_W-1:0]         ma_r, ma_nxt;
  logic [VAL_W-1:0]         mb_r, mb_nxt;
  logic                     neg_r, neg_nxt;
  logic [2*VAL_W-1:0]       acc_r, acc_nxt;
  logic [1:0]               mcnt_r, mcnt_nxt;
  logic signed [VAL_W-1:0]  p_r, p_nxt;
  logic signed [54:0]       np_r, np_nxt;
  logic                     tneg_r, tneg_nxt;

  logic [CFG_W:0]           rem_sh;
  logic                     ge;
  logic signed [VAL_W-1:0]  one;
  logic [KCNT_W-1:0]        kclamp;
  logic signed [63:0]       coef_w;
  logic signed [VAL_W-1:0]  coef;
  logic [VAL_W/2-1:0]       pa, pb;
  logic [VAL_W-1:0]         pp;
  logic [2*VAL_W-1:0]       pp_sh;
  logic                     q_over;
  logic                     q_rem;
  logic [VAL_W:0]           q_inc;
  logic signed [55:0]       t_w;
  logic signed [63:0]       qv;
  logic [KCNT_W-1:0]        term_p1;

  assign one     = VAL_W'(64'd1 << FRAC_BITS);
  assign term_p1 = KCNT_W'(term_r) + 7'd1;

  always_comb begin
    if (nterms_r == '0) begin
      kclamp = 7'd1;
    end else if (nterms_r > KCNT_W'(MAX_TERMS)) begin
      kclamp = KCNT_W'(MAX_TERMS);
    end else begin
      kclamp = nterms_r;
    end
  end

  // Divider step, restoring, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  assign coef_w = $signed(64'({term_r, 1'b1}) << FRAC_BITS) - 64'(x_r);
  assign coef   = sat48(coef_w);

  // Partial product of the 48-bit magnitudes taken as 24-bit halves.
  assign pa = mcnt_r[1] ? ma_r[VAL_W-1:VAL_W/2] : ma_r[VAL_W/2-1:0];
  assign pb = mcnt_r[0] ? mb_r[VAL_W-1:VAL_W/2] : mb_r[VAL_W/2-1:0];
  assign pp = pa * pb;

  always_comb begin
    case (mcnt_r)
      2'd0:    pp_sh = (2*VAL_W)'(pp);
      2'd3:    pp_sh = (2*VAL_W)'(pp) << VAL_W;
      default: pp_sh = (2*VAL_W)'(pp) << (VAL_W/2);
    endcase
  end

  assign q_over = |acc_r[2*VAL_W-1:FRAC_BITS+VAL_W-1];
  assign q_rem  = |acc_r[FRAC_BITS-1:0];
  assign q_inc  = {2'b00, acc_r[FRAC_BITS+VAL_W-2:FRAC_BITS]} + (VAL_W+1)'(q_rem);

  assign t_w = 56'(p_r) - 56'(np_r);
  assign qv  = tneg_r ? -$signed(64'(quo_r)) : $signed(64'(quo_r));

  always_comb begin
    state_nxt  = state_r;
    maxpos_nxt = maxpos_r;
    nterms_nxt = nterms_r;
    k_nxt      = k_r;
    x_nxt      = x_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    term_nxt   = term_r;
    last_nxt   = last_r;
    oval_nxt   = oval_r;
    forx_nxt   = forx_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    dcnt_nxt   = dcnt_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    mcnt_nxt   = mcnt_r;
    p_nxt      = p_r;
    np_nxt     = np_r;
    tneg_nxt   = tneg_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_POSITION: maxpos_nxt = cfg_data;
        CFG_NUM_TERMS:    nterms_nxt = cfg_data[KCNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          k_nxt    = kclamp;
          forx_nxt = 1'b1;
          quo_nxt  = DIV_W'({in_if.position, 1'b0}) << FRAC_BITS;
          rem_nxt  = '0;
          den_nxt  = (maxpos_r > 17'd1) ? maxpos_r - 17'd1 : 17'd1;
          dcnt_nxt = DCNT_W'(DIV_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? CFG_W'(rem_sh - {1'b0, den_r}) : rem_sh[CFG_W-1:0];
        quo_nxt  = {quo_r[DIV_W-2:0], ge};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        oval_nxt  = 1'b1;
        state_nxt = S_OUT;
        if (forx_r) begin
          x_nxt    = XW'(quo_r[FRAC_BITS+16:0]) - (XW'(1) << FRAC_BITS);
          cur_nxt  = one;
          term_nxt = '0;
          last_nxt = (k_r == 7'd1);
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = sat48(qv);
          term_nxt = term_r + 1'b1;
          last_nxt = (term_p1 + 7'd1 == k_r);
        end
      end
      S_OUT: begin
        if (out_if.ready) begin
          oval_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else if (term_r == '0) begin
            // L_1 follows straight from x.
            prev_nxt = cur_r;
            cur_nxt  = sat48($signed(64'(one)) - 64'(x_r));
            term_nxt = IDX_W'(1);
            last_nxt = (k_r == 7'd2);
            oval_nxt = 1'b1;
          end else begin
            state_nxt = S_COEF;
          end
        end
      end
      S_COEF: begin
        ma_nxt    = coef[VAL_W-1] ? VAL_W'(-coef) : VAL_W'(coef);
        mb_nxt    = cur_r[VAL_W-1] ? VAL_W'(-cur_r) : VAL_W'(cur_r);
        neg_nxt   = coef[VAL_W-1] ^ cur_r[VAL_W-1];
        np_nxt    = 55'(prev_r) * 55'($signed({1'b0, term_r}));
        acc_nxt   = '0;
        mcnt_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt  = acc_r + pp_sh;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == 2'd3) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        // Floor of the signed product, taken on the magnitude.
        if (!neg_r) begin
          p_nxt = q_over ? SAT_MAX[VAL_W-1:0] : VAL_W'(acc_r[FRAC_BITS+VAL_W-1:FRAC_BITS]);
        end else begin
          p_nxt = q_over ? SAT_MIN[VAL_W-1:0] : VAL_W'(-q_inc);
        end
        state_nxt = S_SUB;
      end
      S_SUB: begin
        tneg_nxt  = t_w[55];
        quo_nxt   = t_w[55] ? DIV_W'(-t_w) : DIV_W'(t_w);
        rem_nxt   = '0;
        den_nxt   = CFG_W'(term_p1);
        dcnt_nxt  = DCNT_W'(DIV_W - 1);
        forx_nxt  = 1'b0;
        state_nxt = S_DIV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      maxpos_r <= 17'd1024;
      nterms_r <= 7'd64;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      maxpos_r <= maxpos_nxt;
      nterms_r <= nterms_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    x_r    <= x_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    term_r <= term_nxt;
    last_r <= last_nxt;
    forx_r <= forx_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    dcnt_r <= dcnt_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    mcnt_r <= mcnt_nxt;
    p_r    <= p_nxt;
    np_r   <= np_nxt;
    tneg_r <= tneg_nxt;
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = oval_r;
  assign out_if.term_index = term_r;
  assign out_if.term_value = cur_r;
  assign out_if.last_term  = last_r;

endmodule

// File: rtl/lpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the embedding unit, bound into every instance of it.
// ----------------------------------------------------------------------------
module lpe_checker import lpe_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [IDX_W-1:0]        term_index,
  input logic signed [VAL_W-1:0] term_value,
  input logic                    last_term
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(term_value) && $stable(term_index))
    else $error("term item changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("position taken while a term is pending");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("term shown straight after a position item");

  a_l0_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && term_index == '0 |-> term_value == (VAL_W'(64'd1 << FRAC_BITS)))
    else $error("L_0 is not one");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_term |=> in_ready)
    else $error("unit not ready after the final term");

endmodule

bind laguerre_polynomial_embedding_unit lpe_checker #(.FRAC_BITS(FRAC_BITS)) u_lpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .term_index (out_if.term_index),
  .term_value (out_if.term_value),
  .last_term  (out_if.last_term)
);

// File: bench/tb_laguerre_polynomial_embedding_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laguerre_polynomial_embedding_unit
// Self-checking bench for the Laguerre embedding unit. Directed positions
// come first, then random phases with random gaps and random stalls on the
// term channel; one phase has neither. A scoreboard recomputes every term
// from its own copy of the registers and compares the terms in order.
// Register settings change between phases, once the unit has gone idle.
// ----------------------------------------------------------------------------
module tb_laguerre_polynomial_embedding_unit;
  import lpe_pkg::*;

  localparam int FRAC   = 24;
  localparam int KMAX   = 64;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } term_t;

  class term_scoreboard;
    logic [CFG_W-1:0]  max_position;
    logic [KCNT_W-1:0] num_terms;
    term_t             pending_terms[$];
    int                errors;

    function new();
      max_position = 17'd1024;
      num_terms    = 7'd64;
      errors       = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_MAX_POSITION) max_position = data;
      else if (idx == CFG_NUM_TERMS) num_terms = data[KCNT_W-1:0];
    endfunction

    function longint clip48(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    // Accepted position: work out its run of terms.
    function void note_position(logic [POS_W-1:0] pos);
      longint unsigned d, scaled;
      longint x, prev, cur, coef, nxt, t, p;
      logic signed [127:0] prod;
      int k;
      term_t e;
      d = (max_position > 17'd1) ? 64'(max_position - 17'd1) : 64'd1;
      k = (num_terms == '0) ? 1 : (num_terms > KCNT_W'(KMAX) ? KMAX : int'(num_terms));
      scaled = (longint'(pos) * 2) << FRAC;
      x = longint'(scaled / d) - (longint'(1) << FRAC);
      prev = longint'(1) << FRAC;
      e.index = '0; e.value = prev[VAL_W-1:0]; e.last = (k == 1);
      pending_terms.push_back(e);
      if (k == 1) return;
      cur = clip48((longint'(1) << FRAC) - x);
      e.index = IDX_W'(1); e.value = cur[VAL_W-1:0]; e.last = (k == 2);
      pending_terms.push_back(e);
      for (int n = 1; n + 1 < k; n++) begin
        coef = clip48((longint'(2 * n + 1) << FRAC) - x);
        prod = 128'(coef) * 128'(cur);
        prod = prod >>> FRAC;
        if (prod > 128'(SAT_MAX)) p = SAT_MAX;
        else if (prod < 128'(SAT_MIN)) p = SAT_MIN;
        else p = longint'(prod);
        t = p - longint'(n) * prev;
        nxt = clip48(t / longint'(n + 1));
        e.index = IDX_W'(n + 1); e.value = nxt[VAL_W-1:0]; e.last = (n + 2 == k);
        pending_terms.push_back(e);
        prev = cur;
        cur = nxt;
      end
    endfunction

    function void check_term(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                             logic last);
      term_t e;
      if (pending_terms.size() == 0) begin
        $error("unexpected term: term_index %0d term_value %0d", idx, val);
        errors++;
        return;
      end
      e = pending_terms.pop_front();
      if (idx !== e.index) begin
        $error("term_index: expected %0d, got %0d", e.index, idx);
        errors++;
      end
      if (val !== e.value) begin
        $error("term_value: expected %0d, got %0d", e.value, val);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_term: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  lpe_in_if  in_if ();
  lpe_out_if out_if ();

  laguerre_polynomial_embedding_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  term_scoreboard sb = new();
  bit steady_sink;
  int stall_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Term channel back-pressure, changed only at the falling edge.
  always @(negedge clk) begin
    if (!rst_n || steady_sink) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_term(out_if.term_index, out_if.term_value, out_if.last_term);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_position(logic [POS_W-1:0] pos, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.position <= pos;
    do @(posedge clk); while (!in_if.ready);
    sb.note_position(pos);
    @(negedge clk);
  endtask

  // Registers are only written once every term has arrived and the unit
  // has had time to settle.
  task automatic set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    in_if.valid <= 1'b0;
    while (sb.pending_terms.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic random_phase(int count, bit quiet);
    logic [CFG_W-1:0] mp;
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: mp = 17'd2;
      1: mp = 17'd65536;
      2: mp = 17'($urandom_range(2, 300));
      default: mp = 17'($urandom_range(2, 65536));
    endcase
    set_reg(CFG_MAX_POSITION, mp);
    r = $urandom_range(0, 9);
    set_reg(CFG_NUM_TERMS, (r == 0) ? 17'd64 : (r == 1 ? 17'($urandom_range(65, 127))
                                                        : 17'($urandom_range(0, 8))));
    steady_sink = quiet;
    for (int i = 0; i < count; i++)
      send_position((i % 4 == 0) ? POS_W'($urandom_range(0, 65535))
                                 : POS_W'($urandom_range(0, mp)),
                    quiet ? 0 : pick_gap());
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MAX_POSITION;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.position = '0;
    out_if.ready   = 1'b1;
    steady_sink    = 1'b0;
    stall_left     = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: full run of 64 terms at the ends and middle of [-1,1] and past the end.
    send_position(16'd0, 0);
    send_position(16'd1023, 0);
    send_position(16'd512, 2);
    send_position(16'hFFFF, 0);
    // Shortest length, three terms, including positions past the length.
    set_reg(CFG_MAX_POSITION, 17'd2);
    set_reg(CFG_NUM_TERMS, 17'd3);
    send_position(16'd0, 0);
    send_position(16'd1, 1);
    send_position(16'd2, 0);
    send_position(16'hAAAA, 0);
    // Degenerate lengths with zero and excess term counts.
    set_reg(CFG_MAX_POSITION, 17'd0);
    set_reg(CFG_NUM_TERMS, 17'd0);
    send_position(16'd5, 0);
    send_position(16'h5555, 0);
    set_reg(CFG_MAX_POSITION, 17'd1);
    set_reg(CFG_NUM_TERMS, 17'd127);
    send_position(16'd1, 0);
    // Longest length with two terms; a write to a spare index changes nothing.
    set_reg(CFG_MAX_POSITION, 17'd65536);
    set_reg(CFG_NUM_TERMS, 17'd2);
    set_reg(CFG_SPARE, 17'h1FFFF);
    send_position(16'hFFFF, 0);
    send_position(16'd0, 0);
    send_position(16'd32768, 3);

    for (int ph = 0; ph < 6; ph++)
      random_phase(17, (ph == 2));

    in_if.valid <= 1'b0;
    steady_sink = 1'b0;
    while (sb.pending_terms.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
